// ===== rtl/npe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package npe_pkg;

  localparam int UPC_W = 4;

  typedef logic [UPC_W-1:0] upc_t;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_STEP   = 2'd2,
    OP_RSVD   = 2'd3
  } op_t;

  typedef enum logic [4:0] {
    U_NOP,
    U_PV_INIT,
    U_PV_LOADB,
    U_PV_CMP,
    U_EM_INIT,
    U_EMIT,
    U_SC_INIT,
    U_SC_LOADA,
    U_SC_SCAN,
    U_SW_P,
    U_SW_Q,
    U_RV_TEST,
    U_RV_LOADA,
    U_RV_WLO,
    U_RV_WHI,
    U_END
  } uop_t;

  typedef enum logic [2:0] {
    C_NONE,
    C_ALWAYS,
    C_FEW,
    C_PIV_MORE,
    C_NOT_LAST,
    C_NOT_FOUND,
    C_NOT_GREATER,
    C_LO_GE_HI
  } cond_t;

  typedef struct packed {
    uop_t  uop;
    cond_t cond;
    upc_t  target;
  } ctl_t;

  typedef struct packed {
    logic empty;
    logic few;
    logic piv_end;
    logic last;
    logic found;
    logic greater;
    logic lo_ge_hi;
  } stat_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [63:0] key;
  } req_t;

  typedef struct packed {
    logic [63:0] out_key;
    logic [3:0]  position;
    logic        last;
    logic        has_next;
  } res_t;

  localparam upc_t L_START   = 4'd0;
  localparam upc_t L_PV_CMP  = 4'd2;
  localparam upc_t L_EM_INIT = 4'd3;
  localparam upc_t L_EMIT    = 4'd4;
  localparam upc_t L_SC_SCAN = 4'd8;
  localparam upc_t L_RV_TEST = 4'd11;
  localparam upc_t L_END     = 4'd15;

  localparam ctl_t CTL_IDLE = '{uop: U_NOP, cond: C_NONE, target: L_START};

endpackage
`default_nettype wire

// ===== rtl/npe_ucode_rom.sv =====
`timescale 1ns / 1ps
`default_nettype none
module npe_ucode_rom (
  input  npe_pkg::upc_t upc,
  output npe_pkg::ctl_t word
);
  import npe_pkg::*;

  always_comb begin
    case (upc)
      4'd0:    word = '{uop: U_PV_INIT,  cond: C_FEW,         target: L_EM_INIT};
      4'd1:    word = '{uop: U_PV_LOADB, cond: C_NONE,        target: L_START};
      4'd2:    word = '{uop: U_PV_CMP,   cond: C_PIV_MORE,    target: L_PV_CMP};
      4'd3:    word = '{uop: U_EM_INIT,  cond: C_NONE,        target: L_START};
      4'd4:    word = '{uop: U_EMIT,     cond: C_NOT_LAST,    target: L_EMIT};
      4'd5:    word = '{uop: U_NOP,      cond: C_NOT_FOUND,   target: L_END};
      4'd6:    word = '{uop: U_SC_INIT,  cond: C_NONE,        target: L_START};
      4'd7:    word = '{uop: U_SC_LOADA, cond: C_NONE,        target: L_START};
      4'd8:    word = '{uop: U_SC_SCAN,  cond: C_NOT_GREATER, target: L_SC_SCAN};
      4'd9:    word = '{uop: U_SW_P,     cond: C_NONE,        target: L_START};
      4'd10:   word = '{uop: U_SW_Q,     cond: C_NONE,        target: L_START};
      4'd11:   word = '{uop: U_RV_TEST,  cond: C_LO_GE_HI,    target: L_END};
      4'd12:   word = '{uop: U_RV_LOADA, cond: C_NONE,        target: L_START};
      4'd13:   word = '{uop: U_RV_WLO,   cond: C_NONE,        target: L_START};
      4'd14:   word = '{uop: U_RV_WHI,   cond: C_ALWAYS,      target: L_RV_TEST};
      4'd15:   word = '{uop: U_END,      cond: C_NONE,        target: L_START};
      default: word = CTL_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/npe_sequencer.sv =====
`timescale 1ns / 1ps
`default_nettype none
module npe_sequencer (
  input  wire            clk,
  input  wire            rst,
  input  wire            start,
  input  wire [1:0]      operation,
  input  npe_pkg::stat_t st,
  output npe_pkg::ctl_t  ctl,
  output logic           busy
);
  import npe_pkg::*;

  upc_t upc;
  ctl_t word;
  logic taken;

  npe_ucode_rom u_rom (
    .upc  (upc),
    .word (word)
  );

  always_comb begin
    case (word.cond)
      C_NONE:        taken = 1'b0;
      C_ALWAYS:      taken = 1'b1;
      C_FEW:         taken = st.few;
      C_PIV_MORE:    taken = !st.piv_end;
      C_NOT_LAST:    taken = !st.last;
      C_NOT_FOUND:   taken = !st.found;
      C_NOT_GREATER: taken = !st.greater;
      C_LO_GE_HI:    taken = st.lo_ge_hi;
      default:       taken = 1'b0;
    endcase
  end

  assign ctl = busy ? word : CTL_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      upc  <= L_START;
    end else if (!busy) begin
      if (start && operation == OP_STEP && !st.empty) begin
        busy <= 1'b1;
        upc  <= L_START;
      end
    end else if (word.uop == U_END) begin
      busy <= 1'b0;
    end else if (taken) begin
      upc <= word.target;
    end else begin
      upc <= upc + upc_t'(1);
    end
  end

`ifndef SYNTH
  a_start_from_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start) && $past(operation) == OP_STEP)
    else $error("sequencer started without a step request");
`endif

endmodule
`default_nettype wire

// ===== rtl/npe_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module npe_datapath #(
  parameter int MAX_ITEMS = 16,
  parameter int KEY_CHARS = 8
) (
  input  wire            clk,
  input  wire            rst,
  input  wire            accept,
  input  npe_pkg::req_t  request,
  input  npe_pkg::ctl_t  ctl,
  output npe_pkg::stat_t st,
  output npe_pkg::res_t  result,
  output logic           result_strobe
);
  import npe_pkg::*;

  localparam int IW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW = $clog2(MAX_ITEMS + 1);

  function automatic logic [63:0] canon_key(input logic [63:0] k);
    logic [63:0] res;
    logic        stop;
    res  = '0;
    stop = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (i >= KEY_CHARS || k[63-8*i -: 8] == 8'd0) stop = 1'b1;
      if (!stop) res[63-8*i -: 8] = k[63-8*i -: 8];
    end
    return res;
  endfunction

  logic [63:0] mem [MAX_ITEMS];
  logic [63:0] rd;
  logic [63:0] a;
  logic [63:0] b;
  logic [CW-1:0] n;
  logic [IW-1:0] p, q, lo, hi, k;
  logic          found;

  logic [IW-1:0] nm1;
  logic [IW-1:0] raddr;
  logic [IW-1:0] waddr;
  logic [63:0]   wdata;
  logic          we;
  logic          append_ok;
  logic          last_c;

  assign nm1       = IW'(n - CW'(1));
  assign append_ok = accept && request.operation == OP_APPEND && n < CW'(MAX_ITEMS);
  assign last_c    = (k == nm1);

  assign st.empty    = (n == '0);
  assign st.few      = (n < CW'(2));
  assign st.piv_end  = (rd < b) || (p == IW'(1));
  assign st.last     = last_c;
  assign st.found    = found;
  assign st.greater  = (rd > a);
  assign st.lo_ge_hi = (lo >= hi);

  always_comb begin
    case (ctl.uop)
      U_PV_INIT:  raddr = nm1;
      U_PV_LOADB: raddr = p - IW'(1);
      U_PV_CMP:   raddr = p - IW'(2);
      U_EM_INIT:  raddr = '0;
      U_EMIT:     raddr = k + IW'(1);
      U_SC_INIT:  raddr = p;
      U_SC_LOADA: raddr = q;
      U_SC_SCAN:  raddr = q - IW'(1);
      U_RV_TEST:  raddr = lo;
      U_RV_LOADA: raddr = hi;
      default:    raddr = '0;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = rd;
    case (ctl.uop)
      U_SW_P: begin
        we    = 1'b1;
        waddr = p;
        wdata = b;
      end
      U_SW_Q: begin
        we    = 1'b1;
        waddr = q;
        wdata = a;
      end
      U_RV_WLO: begin
        we    = 1'b1;
        waddr = lo;
        wdata = rd;
      end
      U_RV_WHI: begin
        we    = 1'b1;
        waddr = hi;
        wdata = a;
      end
      default: begin
        if (append_ok) begin
          we    = 1'b1;
          waddr = n[IW-1:0];
          wdata = canon_key(request.key);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n             <= '0;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= (ctl.uop == U_EMIT);
      if (accept && request.operation == OP_CLEAR) begin
        n <= '0;
      end else if (append_ok) begin
        n <= n + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.uop)
      U_PV_INIT: begin
        p     <= nm1;
        found <= 1'b0;
      end
      U_PV_LOADB: b <= rd;
      U_PV_CMP: begin
        p <= p - IW'(1);
        b <= rd;
        if (rd < b) found <= 1'b1;
      end
      U_EM_INIT: k <= '0;
      U_EMIT: begin
        k                <= k + IW'(1);
        result.out_key   <= rd;
        result.position  <= 4'(k);
        result.last      <= last_c;
        result.has_next  <= last_c & found;
      end
      U_SC_INIT:  q <= nm1;
      U_SC_LOADA: a <= rd;
      U_SC_SCAN: begin
        if (rd > a) b <= rd;
        else q <= q - IW'(1);
      end
      U_SW_Q: begin
        lo <= p + IW'(1);
        hi <= nm1;
      end
      U_RV_LOADA: a <= rd;
      U_RV_WHI: begin
        lo <= lo + IW'(1);
        hi <= hi - IW'(1);
      end
      default: ;
    endcase
  end

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    n <= CW'(MAX_ITEMS))
    else $error("element count above capacity");
  a_swap_order: assert property (@(posedge clk) disable iff (rst)
    ctl.uop == U_SW_P |-> p < q)
    else $error("successor not right of pivot");
`endif

endmodule
`default_nettype wire

// ===== rtl/next_permutation_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Next-permutation engine. A request is taken when start is high and busy
// is low. Clear and append requests leave busy low; appends past MAX_ITEMS
// keys are dropped, and keys are cut to KEY_CHARS characters and to their
// first zero byte. A step request on a list of n keys raises busy, then
// drives one result per key on result, each marked by result_strobe for one
// cycle in consecutive cycles, with has_next on the last one when a next
// permutation exists; the receiver must take every result as it comes, since
// there is no way to hold them off. After emitting, the list is moved in place
// to its next lexicographic permutation, if there is one. A microcoded
// sequencer runs every step through the single read port of the key memory,
// one microstep per cycle: pivot scan, emit, successor scan, swap and tail
// reversal. A step on an empty list, and operation code 3, do nothing.
module next_permutation_engine #(
  parameter int MAX_ITEMS = 16,
  parameter int KEY_CHARS = 8
) (
  input  wire           clk,
  input  wire           rst,
  input  wire           start,
  input  npe_pkg::req_t request,
  output logic          busy,
  output npe_pkg::res_t result,
  output logic          result_strobe
);
  import npe_pkg::*;

  ctl_t  ctl;
  stat_t st;
  logic  accept;

  assign accept = start && !busy;

  npe_sequencer u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (accept),
    .operation (request.operation),
    .st        (st),
    .ctl       (ctl),
    .busy      (busy)
  );

  npe_datapath #(
    .MAX_ITEMS (MAX_ITEMS),
    .KEY_CHARS (KEY_CHARS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .request       (request),
    .ctl           (ctl),
    .st            (st),
    .result        (result),
    .result_strobe (result_strobe)
  );

`ifndef SYNTH
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> busy)
    else $error("result outside a step");
  a_next_on_last: assert property (@(posedge clk) disable iff (rst)
    result_strobe && result.has_next |-> result.last)
    else $error("has_next on a non-final result");
  a_burst: assert property (@(posedge clk) disable iff (rst)
    result_strobe && !result.last |=> result_strobe &&
      result.position == $past(result.position) + 4'd1)
    else $error("gap or misorder in result burst");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/tb_next_permutation_engine.sv =====
`timescale 1ns / 1ps
module tb_next_permutation_engine;
  import npe_pkg::*;

  localparam int MAX_ITEMS = 16;
  localparam int KEY_CHARS = 8;
  localparam int LIMIT = 400_000;
  localparam int TAIL_CYCLES = 120;
  localparam logic [63:0] KEY_A = 64'h6100_0000_0000_0000;
  localparam logic [63:0] KEY_B = 64'h6200_0000_0000_0000;

  typedef struct packed {
    op_t         op;
    logic [63:0] key;
    logic [4:0]  reps;
    logic        typed;
    res_t        want;
  } row_t;

  logic clk;
  logic rst;
  logic start;
  req_t request;
  logic busy;
  res_t result;
  logic result_strobe;

  logic [63:0] list_keys [MAX_ITEMS];
  int          list_len;
  res_t        due_results [$];
  res_t        last_seen;
  row_t        plan [26];
  bit          calm;

  int errors;
  int effective;
  int arrangements;
  int keys_checked;
  int exhausted;
  int longest;

  next_permutation_engine #(
    .MAX_ITEMS(MAX_ITEMS),
    .KEY_CHARS(KEY_CHARS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .request(request),
    .busy(busy),
    .result(result),
    .result_strobe(result_strobe)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] trim_key(logic [63:0] k);
    logic [63:0] kept;
    bit ended;
    kept = '0;
    ended = 1'b0;
    for (int b = 0; b < 8; b++) begin
      if (b >= KEY_CHARS || k[63-8*b -: 8] == 8'h00) ended = 1'b1;
      if (!ended) kept[63-8*b -: 8] = k[63-8*b -: 8];
    end
    return kept;
  endfunction

  // Moves list_keys to the next lexicographic arrangement; 0 if none.
  function automatic bit next_arrangement();
    int p;
    int q;
    int lo;
    int hi;
    logic [63:0] t;
    if (list_len < 2) return 1'b0;
    p = list_len - 1;
    while (p > 0 && list_keys[p-1] >= list_keys[p]) p--;
    if (p == 0) return 1'b0;
    p--;
    q = list_len - 1;
    while (list_keys[q] <= list_keys[p]) q--;
    t = list_keys[p];
    list_keys[p] = list_keys[q];
    list_keys[q] = t;
    lo = p + 1;
    hi = list_len - 1;
    while (lo < hi) begin
      t = list_keys[lo];
      list_keys[lo] = list_keys[hi];
      list_keys[hi] = t;
      lo++;
      hi--;
    end
    return 1'b1;
  endfunction

  task automatic apply_request(input req_t r);
    logic [63:0] shown [MAX_ITEMS];
    res_t e;
    bit more;
    int n;
    case (op_t'(r.operation))
      OP_CLEAR: begin
        list_len = 0;
        effective++;
      end
      OP_APPEND: begin
        if (list_len < MAX_ITEMS) begin
          list_keys[list_len] = trim_key(r.key);
          list_len++;
          effective++;
          if (list_len > longest) longest = list_len;
        end
      end
      OP_STEP: begin
        n = list_len;
        if (n > 0) begin
          effective++;
          arrangements++;
          shown = list_keys;
          more = next_arrangement();
          if (n >= 2 && !more) exhausted++;
          for (int k = 0; k < n; k++) begin
            e.out_key = shown[k];
            e.position = 4'(k);
            e.last = (k == n - 1);
            e.has_next = (k == n - 1) && more;
            due_results.push_back(e);
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_fields(input res_t want, input res_t got);
    if (got.out_key !== want.out_key) begin
      $error("out_key: expected %h, got %h", want.out_key, got.out_key);
      errors++;
    end
    if (got.position !== want.position) begin
      $error("position: expected %0d, got %0d", want.position, got.position);
      errors++;
    end
    if (got.last !== want.last) begin
      $error("last: expected %0b, got %0b", want.last, got.last);
      errors++;
    end
    if (got.has_next !== want.has_next) begin
      $error("has_next: expected %0b, got %0b", want.has_next, got.has_next);
      errors++;
    end
  endtask

  // results are checked before the request of the same edge is predicted
  always @(posedge clk) begin
    if (!rst) begin
      if (result_strobe) begin
        last_seen = result;
        keys_checked++;
        if (due_results.size() == 0) begin
          $error("unexpected result: key %h position %0d", result.out_key, result.position);
          errors++;
        end else begin
          check_fields(due_results.pop_front(), result);
        end
      end
      if (start && !busy) apply_request(request);
    end
  end

  task automatic send(input op_t op, input logic [63:0] k);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    request <= {op, k};
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [63:0] rand_key();
    logic [63:0] k;
    int len;
    int pos;
    k = '0;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        len = $urandom_range(1, 3);
        for (int b = 0; b < len; b++) k[63-8*b -: 8] = 8'h61 + 8'($urandom_range(0, 2));
      end
      6, 7: k = {$urandom, $urandom};
      8: begin
        k = {$urandom, $urandom};
        pos = $urandom_range(0, 7);
        k[63-8*pos -: 8] = 8'h00;
      end
      default: k = $urandom_range(0, 1) ? '1 : '0;
    endcase
    return k;
  endfunction

  initial begin
    repeat (LIMIT) @(posedge clk);
    $display("tb_next_permutation_engine NOT OK");
    $finish;
  end

  initial begin
    int n;
    int steps;
    rst = 1'b1;
    start = 1'b0;
    request = '0;
    calm = 1'b0;
    last_seen = '0;
    list_len = 0;
    errors = 0;
    effective = 0;
    arrangements = 0;
    keys_checked = 0;
    exhausted = 0;
    longest = 0;

    plan = '{
      '{OP_STEP,   64'h0,                  5'd1,  1'b0, '0},
      '{OP_RSVD,   '1,                     5'd1,  1'b0, '0},
      '{OP_APPEND, '1,                     5'd1,  1'b0, '0},
      '{OP_STEP,   64'h0,                  5'd1,  1'b1, '{'1, 4'd0, 1'b1, 1'b0}},
      '{OP_CLEAR,  '1,                     5'd1,  1'b0, '0},
      '{OP_APPEND, 64'h6200_1234_5678_9ABC, 5'd1,  1'b0, '0},
      '{OP_STEP,   '1,                     5'd1,  1'b1, '{KEY_B, 4'd0, 1'b1, 1'b0}},
      '{OP_APPEND, 64'h0,                  5'd1,  1'b0, '0},
      '{OP_STEP,   64'h0,                  5'd1,  1'b1, '{64'h0, 4'd1, 1'b1, 1'b0}},
      '{OP_STEP,   64'h0,                  5'd1,  1'b1, '{64'h0, 4'd1, 1'b1, 1'b0}},
      '{OP_CLEAR,  64'h0,                  5'd1,  1'b0, '0},
      '{OP_APPEND, KEY_A,                  5'd1,  1'b0, '0},
      '{OP_APPEND, KEY_A,                  5'd1,  1'b0, '0},
      '{OP_APPEND, KEY_B,                  5'd1,  1'b0, '0},
      '{OP_STEP,   64'h0,                  5'd1,  1'b0, '0},
      '{OP_STEP,   64'h0,                  5'd1,  1'b0, '0},
      '{OP_STEP,   64'h0,                  5'd1,  1'b1, '{KEY_A, 4'd2, 1'b1, 1'b0}},
      '{OP_STEP,   64'h0,                  5'd1,  1'b1, '{KEY_A, 4'd2, 1'b1, 1'b0}},
      '{OP_CLEAR,  64'h0,                  5'd1,  1'b0, '0},
      '{OP_APPEND, KEY_A,                  5'd17, 1'b0, '0},
      '{OP_STEP,   64'h0,                  5'd1,  1'b0, '0},
      '{OP_STEP,   64'h0,                  5'd1,  1'b0, '0},
      '{OP_CLEAR,  64'h0,                  5'd1,  1'b0, '0},
      '{OP_APPEND, 64'h8000_0000_0000_0000, 5'd1,  1'b0, '0},
      '{OP_APPEND, 64'h7FFF_FFFF_FFFF_FFFF, 5'd1,  1'b0, '0},
      '{OP_STEP,   64'h0,                  5'd1,  1'b1,
        '{64'h7FFF_FFFF_FFFF_FFFF, 4'd1, 1'b1, 1'b0}}
    };

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      for (int j = 0; j < plan[i].reps; j++) send(plan[i].op, plan[i].key + (64'(j) << 56));
      if (plan[i].typed) begin
        drain();
        check_fields(plan[i].want, last_seen);
      end
    end

    // mostly clear, fill, then step through arrangements; some noise in between
    while (effective < 520) begin
      calm = ($urandom_range(0, 3) == 0);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 18) : $urandom_range(1, 5);
      if ($urandom_range(0, 7) != 0) send(OP_CLEAR, {$urandom, $urandom});
      for (int i = 0; i < n; i++) send(OP_APPEND, rand_key());
      steps = (n <= 4 && $urandom_range(0, 1)) ? 26 : $urandom_range(1, 6);
      for (int i = 0; i < steps; i++) begin
        send(OP_STEP, {$urandom, $urandom});
        if ($urandom_range(0, 15) == 0) send(OP_RSVD, {$urandom, $urandom});
      end
      if ($urandom_range(0, 9) == 0) begin
        send(OP_CLEAR, {$urandom, $urandom});
        send(OP_STEP, {$urandom, $urandom});
      end
      if ($urandom_range(0, 5) == 0) drain();
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (due_results.size() != 0) begin
      $error("%0d expected results never arrived", due_results.size());
      errors++;
    end
    $display("%0d requests took effect, %0d arrangements emitted, %0d keys compared",
             effective, arrangements, keys_checked);
    $display("%0d lists reached their last arrangement, longest list %0d keys",
             exhausted, longest);
    if (errors == 0) begin
      $display("tb_next_permutation_engine OK");
    end else begin
      $display("tb_next_permutation_engine NOT OK");
    end
    $finish;
  end

endmodule
